// ===== rtl/msp_pkg.sv =====
package msp_pkg;

    localparam int CharWidth  = 8;
    localparam int KindWidth  = 3;
    localparam int CauseWidth = 3;
    localparam int NibWidth   = 4;

    // input word: char_in, padded to whole bytes
    localparam int InDataWidth  = 8;
    // output word: byte_out, present, error_cause, padded to whole bytes
    localparam int OutDataWidth = 16;
    localparam int OutUserWidth = KindWidth;

    localparam logic [CharWidth-1:0] ChOpen  = 8'h28;
    localparam logic [CharWidth-1:0] ChClose = 8'h29;
    localparam logic [CharWidth-1:0] ChHash  = 8'h23;

    typedef enum logic [11:0] {
        PH_IDLE  = 12'h001,
        PH_FUNCT = 12'h002,
        PH_AFTF  = 12'h004,
        PH_TAG   = 12'h008,
        PH_DATA  = 12'h010,
        PH_HEXD  = 12'h020,
        PH_TAGSP = 12'h040,
        PH_AFTP  = 12'h080,
        PH_HEXV  = 12'h100,
        PH_RAWD  = 12'h200,
        PH_RAWV  = 12'h400,
        PH_FIN   = 12'h800
    } phase_t;

    typedef enum logic [KindWidth-1:0] {
        K_FUNCT = 3'd0,
        K_TAG   = 3'd1,
        K_VALUE = 3'd2,
        K_PEND  = 3'd3,
        K_DATA  = 3'd4,
        K_DONE  = 3'd5,
        K_ERR   = 3'd6
    } kind_t;

    typedef enum logic [CauseWidth-1:0] {
        C_NONE     = 3'd0,
        C_EMPTY_FN = 3'd1,
        C_PAREN_FN = 3'd2,
        C_PAREN_DV = 3'd3,
        C_UNTERM   = 3'd4
    } cause_t;

    typedef struct packed {
        logic                ok;
        logic [NibWidth-1:0] nib;
    } hex_digit_t;

    function automatic logic is_ws(input logic [CharWidth-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic hex_digit_t hex_val(input logic [CharWidth-1:0] c);
        hex_digit_t r;
        logic [CharWidth-1:0] d;
        r.ok  = 1'b0;
        r.nib = '0;
        d     = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d     = c - 8'h30;
            r.ok  = 1'b1;
            r.nib = d[NibWidth-1:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d     = c - 8'h57;
            r.ok  = 1'b1;
            r.nib = d[NibWidth-1:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d     = c - 8'h37;
            r.ok  = 1'b1;
            r.nib = d[NibWidth-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/message_sexpr_stream_parser.sv =====
// channel | ports                              | word contents (lowest bit up)
// --------+------------------------------------+-----------------------------------------
// input   | s_tvalid s_tready s_tdata s_tlast  | tdata: char_in[7:0]; tlast: last
// output  | m_tvalid m_tready m_tdata m_tuser  | tdata: byte_out[7:0] present[8]
//         |                                    |        error_cause[11:9] zero[15:12]
//         |                                    | tuser: kind[2:0]
//
// one character per cycle sustained while the output is not stalled; a token reaches the output
// through the input register, then decode into the result register
// the parse state updates as the character leaves the input register, so
// the only loop is the state-transition logic
// aresetn is synchronous active low and returns the parser to idle
// a stalled output holds the result register; the input register still
// takes a word while the result register is free or being taken
module message_sexpr_stream_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [msp_pkg::InDataWidth-1:0]   s_tdata,   // char_in[7:0]
    input  logic                              s_tlast,   // last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [msp_pkg::OutDataWidth-1:0]  m_tdata,   // byte_out, present, error_cause
    output logic [msp_pkg::OutUserWidth-1:0]  m_tuser    // kind
);
    import msp_pkg::*;

    // input register
    logic                 in_valid_reg;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_last_reg;

    // parse state
    phase_t              phase_reg, phase_next;
    logic [NibWidth-1:0] held_reg, held_next;
    logic                wait_reg, wait_next;
    logic                inval_reg, inval_next;
    logic                seen_reg, seen_next;
    logic                fempty_reg, fempty_next;

    // result register
    logic                  out_valid_reg;
    kind_t                 out_kind_reg;
    logic [CharWidth-1:0]  out_byte_reg;
    logic                  out_present_reg;
    cause_t                out_cause_reg;

    // decode results
    logic                 emit;
    kind_t                e_kind;
    logic [CharWidth-1:0] e_byte;
    logic                 e_present;
    cause_t               e_cause;
    logic                 do_ds;
    logic                 hex_ok;
    hex_digit_t           hd;
    logic [CharWidth-1:0] c;
    logic                 c_ws;

    // the input register moves on when the result register can take its token
    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign c      = in_char_reg;
    assign c_ws   = is_ws(c);
    assign hd     = hex_val(c);
    assign hex_ok = !inval_reg && seen_reg && !wait_reg;

    always_comb begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        wait_next   = wait_reg;
        inval_next  = inval_reg;
        seen_next   = seen_reg;
        fempty_next = fempty_reg;
        emit        = 1'b0;
        e_kind      = K_FUNCT;
        e_byte      = '0;
        e_present   = 1'b0;
        e_cause     = C_NONE;
        do_ds       = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (c == ChOpen) begin
                    phase_next  = PH_FUNCT;
                    fempty_next = 1'b1;
                end
            end
            PH_FUNCT: begin
                if (c_ws) begin
                    if (fempty_reg) begin
                        phase_next = PH_FIN;
                        emit       = 1'b1;
                        e_kind     = K_ERR;
                        e_cause    = C_EMPTY_FN;
                    end else begin
                        phase_next = PH_AFTF;
                    end
                end else if (c == ChOpen) begin
                    phase_next = PH_FIN;
                    emit       = 1'b1;
                    e_kind     = K_ERR;
                    e_cause    = C_PAREN_FN;
                end else if (c == ChClose) begin
                    phase_next = PH_FIN;
                    emit       = 1'b1;
                    e_kind     = K_DONE;
                end else begin
                    fempty_next = 1'b0;
                    emit        = 1'b1;
                    e_kind      = K_FUNCT;
                    e_byte      = c;
                end
            end
            PH_AFTF, PH_AFTP: begin
                if (!c_ws) begin
                    if (c == ChOpen) phase_next = PH_TAG;
                    else do_ds = 1'b1;
                end
            end
            PH_TAG: begin
                if (c_ws) begin
                    phase_next = PH_TAGSP;
                end else if (c == ChClose) begin
                    phase_next = PH_AFTP;
                    emit       = 1'b1;
                    e_kind     = K_PEND;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_TAG;
                    e_byte = c;
                end
            end
            PH_TAGSP: begin
                if (c == ChOpen) begin
                    phase_next = PH_FIN;
                    emit       = 1'b1;
                    e_kind     = K_ERR;
                    e_cause    = C_PAREN_DV;
                end else if (c == ChClose) begin
                    phase_next = PH_AFTP;
                    emit       = 1'b1;
                    e_kind     = K_PEND;
                end else if (c == ChHash) begin
                    phase_next = PH_HEXV;
                    held_next  = '0;
                    wait_next  = 1'b0;
                    inval_next = 1'b0;
                    seen_next  = 1'b0;
                end else if (!c_ws) begin
                    phase_next = PH_RAWV;
                    emit       = 1'b1;
                    e_kind     = K_VALUE;
                    e_byte     = c;
                end
            end
            PH_DATA: begin
                do_ds = 1'b1;
            end
            PH_HEXD, PH_HEXV: begin
                if (c == ChClose) begin
                    phase_next = (phase_reg == PH_HEXD) ? PH_FIN : PH_AFTP;
                    emit       = 1'b1;
                    e_kind     = (phase_reg == PH_HEXD) ? K_DONE : K_PEND;
                    e_present  = hex_ok;
                end else begin
                    seen_next = 1'b1;
                    if (!inval_reg) begin
                        if (!hd.ok) begin
                            inval_next = 1'b1;
                        end else if (wait_reg) begin
                            emit      = 1'b1;
                            e_kind    = (phase_reg == PH_HEXD) ? K_DATA : K_VALUE;
                            e_byte    = {held_reg, hd.nib};
                            wait_next = 1'b0;
                        end else begin
                            held_next = hd.nib;
                            wait_next = 1'b1;
                        end
                    end
                end
            end
            PH_RAWD: begin
                if (c == ChClose) begin
                    phase_next = PH_FIN;
                    emit       = 1'b1;
                    e_kind     = K_DONE;
                    e_present  = 1'b1;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_DATA;
                    e_byte = c;
                end
            end
            PH_RAWV: begin
                if (c == ChClose) begin
                    phase_next = PH_AFTP;
                    emit       = 1'b1;
                    e_kind     = K_PEND;
                    e_present  = 1'b1;
                end else begin
                    emit   = 1'b1;
                    e_kind = K_VALUE;
                    e_byte = c;
                end
            end
            PH_FIN: begin
            end
            default: begin
            end
        endcase

        // start of the data part (after funct or after a parameter)
        if (do_ds) begin
            phase_next = PH_DATA;
            if (c == ChOpen) begin
                phase_next = PH_FIN;
                emit       = 1'b1;
                e_kind     = K_ERR;
                e_cause    = C_PAREN_DV;
            end else if (c == ChClose) begin
                phase_next = PH_FIN;
                emit       = 1'b1;
                e_kind     = K_DONE;
            end else if (c == ChHash) begin
                phase_next = PH_HEXD;
                held_next  = '0;
                wait_next  = 1'b0;
                inval_next = 1'b0;
                seen_next  = 1'b0;
            end else if (!c_ws) begin
                phase_next = PH_RAWD;
                emit       = 1'b1;
                e_kind     = K_DATA;
                e_byte     = c;
            end
        end

        // end of string: unfinished message turns into an error, then reset
        if (in_last_reg) begin
            if (phase_next != PH_FIN) begin
                emit      = 1'b1;
                e_kind    = K_ERR;
                e_byte    = '0;
                e_present = 1'b0;
                e_cause   = C_UNTERM;
            end
            phase_next  = PH_IDLE;
            held_next   = '0;
            wait_next   = 1'b0;
            inval_next  = 1'b0;
            seen_next   = 1'b0;
            fempty_next = 1'b1;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata[CharWidth-1:0];
            in_last_reg <= s_tlast;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            held_reg   <= '0;
            wait_reg   <= 1'b0;
            inval_reg  <= 1'b0;
            seen_reg   <= 1'b0;
            fempty_reg <= 1'b1;
        end else if (advance) begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            wait_reg   <= wait_next;
            inval_reg  <= inval_next;
            seen_reg   <= seen_next;
            fempty_reg <= fempty_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_kind_reg    <= e_kind;
            out_byte_reg    <= e_byte;
            out_present_reg <= e_present;
            out_cause_reg   <= e_cause;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(OutDataWidth - CharWidth - 1 - CauseWidth){1'b0}},
                       out_cause_reg, out_present_reg, out_byte_reg};

    // a last character always brings the parser back to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> phase_reg == PH_IDLE)
        else $error("parser not idle after last character");

    // an error token carries a cause, any other token none
    a_err_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == K_ERR) == (out_cause_reg != C_NONE)))
        else $error("error cause does not match token kind");

    // present is only set on parameter end and done
    a_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_present_reg |-> (m_tuser == K_PEND || m_tuser == K_DONE))
        else $error("present set on wrong token kind");

    // a held nibble only exists once the hex body has seen a character
    a_nibble: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_reg |-> seen_reg)
        else $error("nibble waiting with no hex character seen");

    // a stalled token is neither lost nor overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled token changed");

endmodule

// ===== dv/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;

    // one character word waiting to go out on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_word_t;

    // one token as the parser should emit it
    typedef struct packed {
        kind_t      kind;
        logic [7:0] val;
        logic       present;
        cause_t     cause;
    } token_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata  = '0;   // char_in[7:0]
    logic                    s_tlast  = 1'b0; // last
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;         // byte_out[7:0] present[8] cause[11:9] pad[15:12]
    logic [OutUserWidth-1:0] m_tuser;         // kind[2:0]

    message_sexpr_stream_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // stimulus and expectation stores
    char_word_t char_q[$];
    token_t     token_q[$];
    logic [7:0] msg_q[$];

    // run statistics
    int n_sent    = 0;
    int n_taken   = 0;
    int n_tokens  = 0;
    int n_done    = 0;
    int n_err     = 0;
    int n_msgs    = 0;
    int n_fail    = 0;

    // parser state as the predictor sees it
    phase_t     pstate   = PH_IDLE;
    logic [3:0] held     = 4'h0;
    logic       nib_wait = 1'b0;
    logic       hex_bad  = 1'b0;
    logic       hex_any  = 1'b0;
    logic       fn_empty = 1'b1;

    // token produced by the current character, if any
    token_t     tok_now;
    logic       tok_hit;

    // ------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------

    // space, tab, newline, vertical tab, form feed, return
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    // nibble value of a hex digit, -1 when not a hex digit
    function automatic int hex_nib(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return int'(c) - 'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return int'(c) - 'h61 + 10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return int'(c) - 'h41 + 10;
        end
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    task automatic put_tok(input kind_t k, input logic [7:0] b, input logic p,
                           input cause_t e);
        tok_now.kind    = k;
        tok_now.val     = b;
        tok_now.present = p;
        tok_now.cause   = e;
        tok_hit         = 1'b1;
    endtask

    task automatic parser_clear();
        pstate   = PH_IDLE;
        held     = 4'h0;
        nib_wait = 1'b0;
        hex_bad  = 1'b0;
        hex_any  = 1'b0;
        fn_empty = 1'b1;
    endtask

    task automatic hex_begin(input phase_t ph);
        pstate   = ph;
        held     = 4'h0;
        nib_wait = 1'b0;
        hex_bad  = 1'b0;
        hex_any  = 1'b0;
    endtask

    function automatic logic hex_good();
        return !hex_bad && hex_any && !nib_wait;
    endfunction

    // one character of a hex body, high nibble first
    task automatic hex_feed(input logic [7:0] c, input kind_t k);
        int v;
        v       = hex_nib(c);
        hex_any = 1'b1;
        if (!hex_bad) begin
            if (v < 0) begin
                hex_bad = 1'b1;
            end else if (nib_wait) begin
                put_tok(k, {held, 4'(v)}, 1'b0, C_NONE);
                nib_wait = 1'b0;
            end else begin
                held     = 4'(v);
                nib_wait = 1'b1;
            end
        end
    endtask

    // start of the data part: a blank keeps waiting, the first non-blank character opens it
    task automatic open_data(input logic [7:0] c);
        pstate = PH_DATA;
        if (c == ChOpen) begin
            pstate = PH_FIN;
            put_tok(K_ERR, 8'h00, 1'b0, C_PAREN_DV);
        end else if (c == ChClose) begin
            pstate = PH_FIN;
            put_tok(K_DONE, 8'h00, 1'b0, C_NONE);
        end else if (c == ChHash) begin
            hex_begin(PH_HEXD);
        end else if (!is_blank(c)) begin
            pstate = PH_RAWD;
            put_tok(K_DATA, c, 1'b0, C_NONE);
        end
    endtask

    // advance the parse by one accepted character, queue its token
    task automatic parse_step(input logic [7:0] c, input logic fin);
        tok_hit         = 1'b0;
        tok_now.kind    = K_FUNCT;
        tok_now.val     = 8'h00;
        tok_now.present = 1'b0;
        tok_now.cause   = C_NONE;
        case (pstate)
            PH_IDLE: begin
                if (c == ChOpen) begin
                    pstate   = PH_FUNCT;
                    fn_empty = 1'b1;
                end
            end
            PH_FUNCT: begin
                if (is_blank(c)) begin
                    if (fn_empty) begin
                        pstate = PH_FIN;
                        put_tok(K_ERR, 8'h00, 1'b0, C_EMPTY_FN);
                    end else begin
                        pstate = PH_AFTF;
                    end
                end else if (c == ChOpen) begin
                    pstate = PH_FIN;
                    put_tok(K_ERR, 8'h00, 1'b0, C_PAREN_FN);
                end else if (c == ChClose) begin
                    pstate = PH_FIN;
                    put_tok(K_DONE, 8'h00, 1'b0, C_NONE);
                end else begin
                    fn_empty = 1'b0;
                    put_tok(K_FUNCT, c, 1'b0, C_NONE);
                end
            end
            PH_AFTF, PH_AFTP: begin
                if (!is_blank(c)) begin
                    if (c == ChOpen) begin
                        pstate = PH_TAG;
                    end else begin
                        open_data(c);
                    end
                end
            end
            PH_TAG: begin
                // tag stops at the first blank; an open paren is a plain tag char
                if (is_blank(c)) begin
                    pstate = PH_TAGSP;
                end else if (c == ChClose) begin
                    pstate = PH_AFTP;
                    put_tok(K_PEND, 8'h00, 1'b0, C_NONE);
                end else begin
                    put_tok(K_TAG, c, 1'b0, C_NONE);
                end
            end
            PH_TAGSP: begin
                if (c == ChOpen) begin
                    pstate = PH_FIN;
                    put_tok(K_ERR, 8'h00, 1'b0, C_PAREN_DV);
                end else if (c == ChClose) begin
                    pstate = PH_AFTP;
                    put_tok(K_PEND, 8'h00, 1'b0, C_NONE);
                end else if (c == ChHash) begin
                    hex_begin(PH_HEXV);
                end else if (!is_blank(c)) begin
                    pstate = PH_RAWV;
                    put_tok(K_VALUE, c, 1'b0, C_NONE);
                end
            end
            PH_DATA: begin
                open_data(c);
            end
            PH_HEXD: begin
                if (c == ChClose) begin
                    pstate = PH_FIN;
                    put_tok(K_DONE, 8'h00, hex_good(), C_NONE);
                end else begin
                    hex_feed(c, K_DATA);
                end
            end
            PH_HEXV: begin
                if (c == ChClose) begin
                    pstate = PH_AFTP;
                    put_tok(K_PEND, 8'h00, hex_good(), C_NONE);
                end else begin
                    hex_feed(c, K_VALUE);
                end
            end
            PH_RAWD: begin
                if (c == ChClose) begin
                    pstate = PH_FIN;
                    put_tok(K_DONE, 8'h00, 1'b1, C_NONE);
                end else begin
                    put_tok(K_DATA, c, 1'b0, C_NONE);
                end
            end
            PH_RAWV: begin
                if (c == ChClose) begin
                    pstate = PH_AFTP;
                    put_tok(K_PEND, 8'h00, 1'b1, C_NONE);
                end else begin
                    put_tok(K_VALUE, c, 1'b0, C_NONE);
                end
            end
            default: begin
            end
        endcase
        // last char: unfinished message turns into an unterminated error
        if (fin) begin
            if (pstate != PH_FIN) begin
                put_tok(K_ERR, 8'h00, 1'b0, C_UNTERM);
            end
            parser_clear();
        end
        if (tok_hit) begin
            token_q.push_back(tok_now);
        end
    endtask

    // ------------------------------------------------------------------
    // message generation
    // ------------------------------------------------------------------

    // random byte, leaning on the characters the grammar cares about
    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 15))
            0:       return ChOpen;
            1:       return ChClose;
            2:       return ChHash;
            3:       return 8'h20;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] any_but_close();
        logic [7:0] c;
        do c = any_char(); while (c == ChClose);
        return c;
    endfunction

    // usable as a funct char or the first char of a raw body
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == ChOpen || c == ChClose || c == ChHash);
        return c;
    endfunction

    function automatic logic [7:0] tag_char();
        logic [7:0] c;
        do c = any_char(); while (is_blank(c) || c == ChClose);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'h20 : 8'(8 + r);
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] nonhex_char();
        logic [7:0] c;
        do c = any_char(); while (hex_nib(c) >= 0 || c == ChClose);
        return c;
    endfunction

    // value or data body, closing paren not included
    task automatic add_body();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3) begin
            msg_q.push_back(ChHash);
            repeat (2 * $urandom_range(1, 3)) msg_q.push_back(hex_char());
        end else if (r == 4) begin
            // odd digit count
            msg_q.push_back(ChHash);
            repeat (2 * $urandom_range(0, 1) + 1) msg_q.push_back(hex_char());
        end else if (r == 5) begin
            msg_q.push_back(ChHash);
        end else if (r == 6) begin
            // bad digit somewhere in the body
            msg_q.push_back(ChHash);
            repeat ($urandom_range(0, 2)) msg_q.push_back(hex_char());
            msg_q.push_back(nonhex_char());
            repeat ($urandom_range(0, 2)) msg_q.push_back(any_but_close());
        end else begin
            msg_q.push_back(plain_char());
            repeat ($urandom_range(0, 4)) msg_q.push_back(any_but_close());
        end
    endtask

    task automatic push_text(input string s);
        foreach (s[i]) char_q.push_back('{ch: s[i], fin: (i == s.len() - 1)});
    endtask

    // mostly well-formed messages, some cut short, damaged or pure noise
    task automatic gen_message();
        int r;
        int cut;
        msg_q = {};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(0, 39)));
        end
        msg_q.push_back(ChOpen);
        if ($urandom_range(0, 15) != 0) begin
            repeat ($urandom_range(1, 4)) msg_q.push_back(plain_char());
        end
        repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(1, 2)) msg_q.push_back(blank_char());
            msg_q.push_back(ChOpen);
            repeat ($urandom_range(0, 3)) msg_q.push_back(tag_char());
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 2)) msg_q.push_back(blank_char());
                if ($urandom_range(0, 4) != 0) begin
                    add_body();
                end
            end
            msg_q.push_back(ChClose);
        end
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 2)) msg_q.push_back(blank_char());
            add_body();
        end
        msg_q.push_back(ChClose);

        r = $urandom_range(0, 99);
        if (r < 8) begin
            cut   = $urandom_range(1, msg_q.size());
            msg_q = msg_q[0:cut-1];
        end else if (r < 13) begin
            msg_q[$urandom_range(0, msg_q.size() - 1)] = any_char();
        end else if (r < 17) begin
            msg_q = {};
            repeat ($urandom_range(1, 6)) msg_q.push_back(any_char());
        end else if (r < 30) begin
            // junk after the closing paren is skipped until last
            repeat ($urandom_range(1, 3)) msg_q.push_back(any_char());
        end

        foreach (msg_q[i]) char_q.push_back('{ch: msg_q[i], fin: (i == msg_q.size() - 1)});
        n_msgs++;
    endtask

    // ------------------------------------------------------------------
    // idling phases, switched every 160 words sent
    // ------------------------------------------------------------------

    function automatic int src_idle_pct();
        case ((n_sent / 160) % 4)
            1:       return 59;
            3:       return 36;
            default: return 0;
        endcase
    endfunction

    function automatic int snk_stall_pct();
        case ((n_sent / 160) % 4)
            2:       return 59;
            3:       return 36;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: feeds char_q onto the input channel
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : drv
        logic       load;
        char_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            load = (char_q.size() != 0) && ($urandom_range(0, 99) >= src_idle_pct());
            if (load) begin
                w       = char_q.pop_front();
                s_tdata <= w.ch;
                s_tlast <= w.fin;
                n_sent  <= n_sent + 1;
            end
            s_tvalid <= load;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct());
    end

    // ------------------------------------------------------------------
    // monitor: predicts on input handshakes, checks output handshakes
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : mon
        token_t want;
        if (aresetn && s_tvalid && s_tready) begin
            parse_step(s_tdata, s_tlast);
            n_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                $error("unexpected token: kind %0d tdata %h", m_tuser, m_tdata);
                n_fail++;
            end else begin
                want = token_q.pop_front();
                n_tokens++;
                if (want.kind == K_DONE) n_done++;
                if (want.kind == K_ERR) n_err++;
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    n_fail++;
                end
                if (m_tdata[7:0] !== want.val) begin
                    $error("byte_out: expected %h, got %h", want.val, m_tdata[7:0]);
                    n_fail++;
                end
                if (m_tdata[8] !== want.present) begin
                    $error("present: expected %0d, got %0d", want.present, m_tdata[8]);
                    n_fail++;
                end
                if (m_tdata[11:9] !== want.cause) begin
                    $error("error_cause: expected %0d, got %0d", want.cause, m_tdata[11:9]);
                    n_fail++;
                end
                if (m_tdata[15:12] !== 4'h0) begin
                    $error("tdata pad: expected 0, got %h", m_tdata[15:12]);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        // leading text, empty funct done, junk after done up to last
        push_text("z()x");
        // blank right after the open paren
        push_text("( ");
        // open paren inside the funct
        push_text("(a(");
        // hex value in both cases, raw value, odd-length hex data
        push_text("(f (t #aF)(u x) #1)");
        // zero and 0xff as funct chars, last one cut by unterminated
        char_q.push_back('{ch: ChOpen, fin: 1'b0});
        char_q.push_back('{ch: 8'h67, fin: 1'b0});
        char_q.push_back('{ch: 8'h00, fin: 1'b0});
        char_q.push_back('{ch: 8'hff, fin: 1'b1});

        while (char_q.size() < 1530) gen_message();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // all words taken, all tokens seen, then a short tail
        while (char_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (token_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d words in %0d messages, %0d tokens checked", n_taken, n_msgs, n_tokens);
        $display("%0d done and %0d error events, four idling phases", n_done, n_err);
        if (n_fail == 0) begin
            $display("PASS message_sexpr_stream_parser");
        end else begin
            $display("FAIL message_sexpr_stream_parser");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAIL message_sexpr_stream_parser");
        $finish;
    end

endmodule

// ===== message_sexpr_stream_parser.f =====
rtl/msp_pkg.sv
rtl/message_sexpr_stream_parser.sv
dv/tb.sv
